// ----- src/edt_pkg.sv -----
// Package for the edit distance core: item types, opcodes, edit codes, sizes.
// Used by edit_distance_with_traceback_core.
package edt_pkg;

  localparam int MaxLenDefault = 32;
  localparam int SymbolBits    = 8;

  localparam logic [1:0] OpcAppendA = 2'd0;
  localparam logic [1:0] OpcAppendB = 2'd1;
  localparam logic [1:0] OpcCompute = 2'd2;

  localparam logic [2:0] EdMatch  = 3'd0;
  localparam logic [2:0] EdSubst  = 3'd1;
  localparam logic [2:0] EdDelete = 3'd2;
  localparam logic [2:0] EdInsert = 3'd3;
  localparam logic [2:0] EdNone   = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [2:0] edit_op;
    logic [5:0] distance;
    logic       overflowed;
    logic       last;
  } out_item_t;

endpackage

// ----- src/edit_distance_with_traceback_core.sv -----
// Edit distance core: word stores, cost matrix and op stack RAMs, fill and traceback sequencer.
// Depends on edt_pkg and edt_ram.
//
//  channel | dir | handshake                | payload
//  in      | in  | in_valid_i, in_stall_o   | in_item_i  (opcode, symbol)
//  out     | out | out_valid_o, out_stall_i | out_item_o (edit_op, distance, overflowed, last)
//
// Appends are taken one per cycle while idle. A compute fills the matrix at one
// step per border cell and two per inner cell (read up, then compare and write),
// walks back at one step per border step and five per inner step (a check, three
// reads, a compare) plus one closing check, then pops each result by a read and
// an output step while the output is free. Fill and walk share one compare unit.
// Reset is asynchronous and clears the lengths, the overflow flag and the sequencer.
// The input is stalled for the whole compute; a stalled output holds the result and the pop.
module edit_distance_with_traceback_core
  import edt_pkg::*;
#(
  parameter int MaxLen = MaxLenDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);
  localparam int Dim   = MaxLen + 1;
  localparam int Cells = Dim * Dim;
  localparam int AW    = $clog2(Cells);
  localparam int IW    = $clog2(Dim);
  localparam int WW    = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int SD    = 2 * MaxLen;
  localparam int SAW   = $clog2(SD);
  localparam int SW    = $clog2(SD + 1);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StFRd   = 4'd1;
  localparam logic [3:0] StFWr   = 4'd2;
  localparam logic [3:0] StTStep = 4'd3;
  localparam logic [3:0] StTRdD  = 4'd4;
  localparam logic [3:0] StTRdU  = 4'd5;
  localparam logic [3:0] StTRdL  = 4'd6;
  localparam logic [3:0] StTDec  = 4'd7;
  localparam logic [3:0] StERd   = 4'd8;
  localparam logic [3:0] StEOut  = 4'd9;

  logic [3:0]    state_q;
  logic [IW-1:0] len_a_q, len_b_q, i_q, j_q;
  logic          ovf_q;
  logic [5:0]    dist_q, d_q, u_q, l_q;
  logic [SW-1:0] cnt_q;
  logic          out_valid_q;
  out_item_t     out_q;

  // Word stores
  logic [SymbolBits-1:0] word_a_q [MaxLen];
  logic [SymbolBits-1:0] word_b_q [MaxLen];

  // Matrix RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [5:0]    ram_wdata, ram_rdata;

  edt_ram #(.Width(6), .Depth(Cells)) u_matrix (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Op stack RAM
  logic           stk_we;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [2:0]     stk_wdata, stk_rdata;

  edt_ram #(.Width(3), .Depth(SD)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(Dim) + AW'(c);
  endfunction

  logic accept, load_a, load_b;
  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign load_a      = accept && (in_item_i.opcode == OpcAppendA) && (len_a_q < IW'(MaxLen));
  assign load_b      = accept && (in_item_i.opcode == OpcAppendB) && (len_b_q < IW'(MaxLen));
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  logic [IW-1:0] im1, jm1;
  assign im1 = i_q - IW'(1);
  assign jm1 = j_q - IW'(1);

  logic          at_border, row_end, fill_end, both_empty, emit_go;
  logic [SW-1:0] cnt_m1;
  assign at_border  = (i_q == '0) || (j_q == '0);
  assign row_end    = (j_q == len_b_q);
  assign fill_end   = row_end && (i_q == len_a_q);
  assign both_empty = (len_a_q == '0) && (len_b_q == '0);
  assign emit_go    = !out_valid_q || !out_stall_i;
  assign cnt_m1     = cnt_q - SW'(1);

  // Shared compare unit: tie order of diagonal, up, left
  logic [5:0] cmp_u, cmp_l, fill_v, border_v;
  logic       pick_d, pick_u, sym_ne;
  logic [2:0] step_op;
  always_comb begin
    cmp_u    = (state_q == StFWr) ? ram_rdata : u_q;
    cmp_l    = (state_q == StTDec) ? ram_rdata : l_q;
    pick_d   = (d_q <= cmp_u) && (d_q <= cmp_l);
    pick_u   = !pick_d && (cmp_u <= cmp_l);
    sym_ne   = word_a_q[im1[WW-1:0]] != word_b_q[jm1[WW-1:0]];
    border_v = (i_q == '0) ? 6'(j_q) : 6'(i_q);
    if (pick_d) begin
      fill_v  = d_q + {5'd0, sym_ne};
      step_op = sym_ne ? EdSubst : EdMatch;
    end else if (pick_u) begin
      fill_v  = cmp_u + 6'd1;
      step_op = EdDelete;
    end else begin
      fill_v  = cmp_l + 6'd1;
      step_op = EdInsert;
    end
  end

  // Matrix read address and write port
  always_comb begin
    ram_we    = (state_q == StFWr);
    ram_waddr = cell_addr(i_q, j_q);
    ram_wdata = at_border ? border_v : fill_v;
    case (state_q)
      StFRd, StTRdU: ram_raddr = cell_addr(im1, j_q);
      StTRdD:        ram_raddr = cell_addr(im1, jm1);
      StTRdL:        ram_raddr = cell_addr(i_q, jm1);
      default:       ram_raddr = '0;
    endcase
  end

  // Push traceback ops; pop from the top
  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = step_op;
    case (state_q)
      StTStep: begin
        if (both_empty) begin
          stk_we    = 1'b1;
          stk_wdata = EdNone;
        end else if (i_q == '0 && j_q != '0) begin
          stk_we    = 1'b1;
          stk_wdata = EdInsert;
        end else if (j_q == '0 && i_q != '0) begin
          stk_we    = 1'b1;
          stk_wdata = EdDelete;
        end
      end
      StTDec:  stk_we = 1'b1;
      default: ;
    endcase
  end
  assign stk_waddr = cnt_q[SAW-1:0];
  assign stk_raddr = cnt_m1[SAW-1:0];

  // Store appended symbols at the current length
  always_ff @(posedge clk_i) begin
    if (load_a) begin
      word_a_q[len_a_q[WW-1:0]] <= in_item_i.symbol[SymbolBits-1:0];
    end
    if (load_b) begin
      word_b_q[len_b_q[WW-1:0]] <= in_item_i.symbol[SymbolBits-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_a_q     <= '0;
      len_b_q     <= '0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      d_q         <= '0;
      u_q         <= '0;
      l_q         <= '0;
      dist_q      <= '0;
    end else begin
      // Drop the result once taken, set it when a new one is loaded
      if (state_q == StEOut && emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            case (in_item_i.opcode)
              OpcAppendA: begin
                if (load_a) begin
                  len_a_q <= len_a_q + IW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              OpcAppendB: begin
                if (load_b) begin
                  len_b_q <= len_b_q + IW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              OpcCompute: begin
                i_q     <= '0;
                j_q     <= '0;
                cnt_q   <= '0;
                state_q <= StFWr;
              end
              default: ;
            endcase
          end
        end
        StFRd: state_q <= StFWr;
        StFWr: begin
          // Written cell is the next left; up becomes the next diagonal
          l_q <= ram_wdata;
          if (at_border) begin
            d_q <= 6'(im1);
          end else begin
            d_q <= ram_rdata;
          end
          if (fill_end) begin
            dist_q  <= ram_wdata;
            state_q <= StTStep;
          end else if (row_end) begin
            i_q     <= i_q + IW'(1);
            j_q     <= '0;
            state_q <= StFWr;
          end else begin
            j_q     <= j_q + IW'(1);
            state_q <= (i_q == '0) ? StFWr : StFRd;
          end
        end
        StTStep: begin
          if (both_empty) begin
            cnt_q   <= cnt_q + SW'(1);
            state_q <= StERd;
          end else if (i_q == '0 && j_q == '0) begin
            state_q <= StERd;
          end else if (i_q == '0) begin
            cnt_q <= cnt_q + SW'(1);
            j_q   <= jm1;
          end else if (j_q == '0) begin
            cnt_q <= cnt_q + SW'(1);
            i_q   <= im1;
          end else begin
            state_q <= StTRdD;
          end
        end
        StTRdD: state_q <= StTRdU;
        StTRdU: begin
          d_q     <= ram_rdata;
          state_q <= StTRdL;
        end
        StTRdL: begin
          u_q     <= ram_rdata;
          state_q <= StTDec;
        end
        StTDec: begin
          cnt_q <= cnt_q + SW'(1);
          if (pick_d) begin
            i_q <= im1;
            j_q <= jm1;
          end else if (pick_u) begin
            i_q <= im1;
          end else begin
            j_q <= jm1;
          end
          state_q <= StTStep;
        end
        StERd: state_q <= StEOut;
        StEOut: begin
          if (emit_go) begin
            out_q.edit_op    <= stk_rdata;
            out_q.distance   <= dist_q;
            out_q.overflowed <= ovf_q;
            out_q.last       <= (cnt_q == SW'(1));
            cnt_q            <= cnt_m1;
            if (cnt_q == SW'(1)) begin
              len_a_q <= '0;
              len_b_q <= '0;
              ovf_q   <= 1'b0;
              state_q <= StIdle;
            end else begin
              state_q <= StERd;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ----- src/edt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module edt_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
